### sv/bsff_pkg.sv
// Package with shared types and constants for the bitmap store with find-free.
package bsff_pkg;

    localparam int NUM_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 64;
    localparam int CNT_W         = 11;
    localparam int FREE_W        = 10;
    localparam int OP_W          = 2;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_SET    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TOGGLE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] start_bit;
        logic [CNT_W-1:0] end_bit;
    } in_word_t;

    typedef struct packed {
        logic              bit_value;
        logic              bad_request;
        logic [CNT_W-1:0]  set_total;
        logic [CNT_W-1:0]  unset_total;
        logic [CNT_W-1:0]  low_zero_run;
        logic [CNT_W-1:0]  high_zero_run;
        logic [FREE_W-1:0] first_free;
        logic              no_free;
    } out_word_t;

    // Per-word scan results handed from the word unit to the accumulator.
    typedef struct packed {
        logic [6:0] ones;
        logic       any_one;
        logic [5:0] low_one;
        logic [5:0] high_one;
        logic       any_zero;
        logic [5:0] low_zero;
    } word_stat_t;

endpackage

### sv/bsff_word_unit.sv
// Shared word unit: range masking for updates and bit statistics of one masked word.
module bsff_word_unit (
    input  logic [63:0]                  word_in,
    input  logic [bsff_pkg::CNT_W+5:0]   word_base,
    input  logic [bsff_pkg::CNT_W-1:0]   lo_bit,
    input  logic [bsff_pkg::CNT_W-1:0]   hi_bit,
    output logic [63:0]                  range_mask,
    output bsff_pkg::word_stat_t         stat
);
    import bsff_pkg::*;

    logic [63:0] masked;

    // Mask of bits in this word whose index lies in [lo_bit, hi_bit).
    always_comb
    begin
        logic [CNT_W+6:0] idx;
        for (int b = 0; b < 64; b++)
        begin
            idx = {1'b0, word_base} + (CNT_W+7)'(b);
            range_mask[b] = (idx >= (CNT_W+7)'(lo_bit)) && (idx < (CNT_W+7)'(hi_bit));
        end
    end

    assign masked = word_in & range_mask;

    // Popcount, first and last set bit, and first unset in-range bit.
    always_comb
    begin
        stat = '0;
        for (int b = 0; b < 64; b++)
        begin
            stat.ones = stat.ones + 7'(masked[b]);
        end
        for (int b = 63; b >= 0; b--)
        begin
            if (masked[b])
            begin
                stat.any_one = 1'b1;
                stat.low_one = 6'(b);
            end
            if (range_mask[b] && !masked[b])
            begin
                stat.any_zero = 1'b1;
                stat.low_zero = 6'(b);
            end
        end
        for (int b = 0; b < 64; b++)
        begin
            if (masked[b])
            begin
                stat.high_one = 6'(b);
            end
        end
    end

endmodule

### sv/bsff_ctrl.sv
// Sequencer state machine for update pass and scan pass.
module bsff_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start_item,
    input  logic                 do_update,
    input  logic                 last_word,
    input  logic                 out_taken,
    output bsff_pkg::state_t     state,
    output logic                 busy
);
    import bsff_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (start_item) state_next = do_update ? ST_UPD_RD : ST_SCAN_RD;
            ST_UPD_RD:   state_next = ST_UPD_WR;
            ST_UPD_WR:   state_next = last_word ? ST_SCAN_RD : ST_UPD_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_ACC;
            ST_SCAN_ACC: state_next = last_word ? ST_DONE : ST_SCAN_RD;
            ST_DONE:     if (out_taken) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        state = state_reg;
        busy  = (state_reg != ST_IDLE);
    end

endmodule

### sv/bitmap_store_with_find_free_top.sv
// Top level of the bitmap store with find-free.
// An item without a store update runs a scan pass; one with an update runs an update pass
// and then a scan pass. The single-port word memory and the one shared word unit set this:
// each pass walks the W = NUM_BITS/64 words of the store (16 by default) one by one, with a
// read state and a write or accumulate state per word, and a done state and the idle state
// follow. The input stalls while an item is in work; a result waits in an output register
// until taken, and the input is free again in the cycle after it is taken. The memory has a
// valid bit per word, so an unwritten word reads as zero, no clearing pass is needed and the
// block is ready right after reset.
module bitmap_store_with_find_free_top #(
    parameter int NUM_BITS  = bsff_pkg::NUM_BITS_DEF,
    parameter int WORD_BITS = bsff_pkg::WORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bsff_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bsff_pkg::in_word_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bsff_pkg::out_word_t        out_data
);
    import bsff_pkg::*;

    localparam int WORDS = NUM_BITS / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NW    = $clog2(NUM_BITS + 1);

    state_t state;
    logic   busy, start_item, last_word;

    logic [CNT_W-1:0] bit_count_reg;
    logic [NW-1:0]    used_full;
    logic [CNT_W-1:0] n_reg;
    in_word_t         item_reg;
    logic             bad_reg, before_reg, upd_reg;
    logic [AW-1:0]    addr_reg;
    logic [63:0]      mem [WORDS];
    logic [WORDS-1:0] vld_reg;
    logic [63:0]      rd_reg;
    logic [CNT_W-1:0] set_reg, low_reg, high_reg, free_reg;
    logic             any_one_reg, any_zero_reg, qbit_reg;
    out_word_t        out_reg;

    logic [63:0]      range_mask;
    word_stat_t       stat;
    logic [CNT_W+5:0] word_base;
    logic [CNT_W-1:0] lo_bit, hi_bit, n_now;
    logic             bad_now;
    logic             upd_now;

    assign used_full = (NW'(bit_count_reg) > NW'(NUM_BITS)) ? NW'(NUM_BITS) : NW'(bit_count_reg);
    assign n_now     = CNT_W'(used_full);

    assign start_item = in_valid && !busy;
    assign in_stall   = busy;
    assign last_word  = (addr_reg == AW'(WORDS - 1));
    assign out_valid  = (state == ST_DONE);
    assign out_data   = out_reg;

    bsff_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_item (start_item),
        .do_update  (upd_now),
        .last_word  (last_word),
        .out_taken  (!out_stall),
        .state      (state),
        .busy       (busy)
    );

    // Range check for an arriving word.
    always_comb
    begin
        case (op_t'(in_data.op))
            OP_SET, OP_CLEAR: bad_now = (in_data.end_bit > n_now) ||
                                        (in_data.start_bit > in_data.end_bit);
            OP_TOGGLE:        bad_now = (in_data.start_bit >= n_now);
            default:          bad_now = 1'b0;
        endcase
    end

    // An arriving word needs the update pass when it is good and changes the store.
    assign upd_now = !bad_now && (op_t'(in_data.op) != OP_QUERY);

    // Shared unit operands: update range during update pass, used range during scan.
    assign word_base = (CNT_W+6)'(addr_reg) << 6;
    always_comb
    begin
        if (state == ST_UPD_WR)
        begin
            lo_bit = item_reg.start_bit;
            hi_bit = (op_t'(item_reg.op) == OP_TOGGLE) ? item_reg.start_bit + CNT_W'(1)
                                                      : item_reg.end_bit;
        end
        else
        begin
            lo_bit = '0;
            hi_bit = n_reg;
        end
    end

    bsff_word_unit u_word (
        .word_in    (rd_reg),
        .word_base  (word_base),
        .lo_bit     (lo_bit),
        .hi_bit     (hi_bit),
        .range_mask (range_mask),
        .stat       (stat)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_count_reg <= CNT_W'(1024);
        else if (cfg_we)
            bit_count_reg <= cfg_wdata;
    end

    // Word valid bits stand for the reset value of the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (state == ST_UPD_WR)
            vld_reg[addr_reg] <= 1'b1;
    end

    // Word memory, single port.
    always_ff @(posedge clk)
    begin
        if (state == ST_UPD_WR)
        begin
            case (op_t'(item_reg.op))
                OP_SET:    mem[addr_reg] <= rd_reg | range_mask;
                OP_CLEAR:  mem[addr_reg] <= rd_reg & ~range_mask;
                default:   mem[addr_reg] <= rd_reg ^ range_mask;
            endcase
        end
        if (state == ST_UPD_RD || state == ST_SCAN_RD)
            rd_reg <= vld_reg[addr_reg] ? mem[addr_reg] : '0;
    end

    // Item capture, word address and scan accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            upd_reg  <= 1'b0;
        end
        else
        begin
            case (state)
                ST_IDLE:
                begin
                    addr_reg <= '0;
                    if (start_item)
                        upd_reg <= upd_now;
                end
                ST_UPD_WR:   addr_reg <= last_word ? '0 : addr_reg + AW'(1);
                ST_SCAN_ACC: addr_reg <= last_word ? '0 : addr_reg + AW'(1);
                default:     addr_reg <= addr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_item)
        begin
            item_reg     <= in_data;
            bad_reg      <= bad_now;
            n_reg        <= n_now;
            set_reg      <= '0;
            any_one_reg  <= 1'b0;
            any_zero_reg <= 1'b0;
            low_reg      <= n_now;
            high_reg     <= n_now;
            free_reg     <= '0;
            before_reg   <= 1'b0;
        end
        // Bit at start before the change is picked up in the first pass that reads it.
        if ((state == ST_UPD_WR || (state == ST_SCAN_ACC && !upd_reg)) &&
            (item_reg.start_bit[CNT_W-1:6] == (CNT_W-6)'(addr_reg)) &&
            (item_reg.start_bit < n_reg))
            before_reg <= rd_reg[item_reg.start_bit[5:0]];
        if (state == ST_SCAN_ACC)
        begin
            set_reg <= set_reg + CNT_W'(stat.ones);
            if (stat.any_one && !any_one_reg)
            begin
                any_one_reg <= 1'b1;
                low_reg     <= CNT_W'(word_base) + CNT_W'(stat.low_one);
            end
            if (stat.any_one)
                high_reg <= n_reg - CNT_W'(1) - (CNT_W'(word_base) + CNT_W'(stat.high_one));
            if (stat.any_zero && !any_zero_reg)
            begin
                any_zero_reg <= 1'b1;
                free_reg     <= CNT_W'(word_base) + CNT_W'(stat.low_zero);
            end
        end
        if (state == ST_SCAN_ACC && last_word)
            qbit_reg <= 1'b1;
        else if (start_item)
            qbit_reg <= 1'b0;
    end

    // Result word, assembled combinationally from the item and scan registers.
    always_comb
    begin
        out_reg.bit_value     = before_reg;
        out_reg.bad_request   = bad_reg;
        out_reg.set_total     = set_reg;
        out_reg.unset_total   = n_reg - set_reg;
        out_reg.low_zero_run  = low_reg;
        out_reg.high_zero_run = high_reg;
        out_reg.first_free    = free_reg[FREE_W-1:0];
        out_reg.no_free       = !any_zero_reg || !qbit_reg;
    end

endmodule

### dv/bitmap_store_with_find_free_checker.sv
// Checker that predicts and compares every result word of the bitmap store.
`timescale 1ns / 100ps
module bitmap_store_with_find_free_checker
    import bsff_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_word_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_word_t            out_data,
    output int                   mismatch_count,
    output int                   pending_count
);
    localparam int MAP_BITS = NUM_BITS_DEF;

    logic [MAP_BITS-1:0] shadow_map;
    logic [CNT_W-1:0]    shadow_count;
    out_word_t           expected_words[$];

    // Applies one request to the shadow bitmap and returns the expected result word.
    function automatic out_word_t predict_request(input in_word_t req);
        out_word_t res;
        int n;
        int set_bits;
        int s;
        int e;
        logic found_free;
        logic found_one;
        n = (shadow_count > MAP_BITS) ? MAP_BITS : int'(shadow_count);
        s = int'(req.start_bit);
        e = int'(req.end_bit);
        res = '0;
        res.bit_value = (s < n) ? shadow_map[s] : 1'b0;
        case (op_t'(req.op))
            OP_SET, OP_CLEAR:
            begin
                if (e > n || s > e)
                    res.bad_request = 1'b1;
                else
                    for (int i = s; i < e; i++)
                        shadow_map[i] = (op_t'(req.op) == OP_SET);
            end
            OP_TOGGLE:
            begin
                if (s >= n)
                    res.bad_request = 1'b1;
                else
                    shadow_map[s] = ~shadow_map[s];
            end
            default:
            begin
            end
        endcase
        // Summary scan over the bits in use only.
        set_bits = 0;
        found_free = 1'b0;
        found_one = 1'b0;
        res.low_zero_run = CNT_W'(n);
        res.high_zero_run = CNT_W'(n);
        for (int i = 0; i < n; i++)
        begin
            if (shadow_map[i])
            begin
                set_bits++;
                if (!found_one)
                    res.low_zero_run = CNT_W'(i);
                found_one = 1'b1;
                res.high_zero_run = CNT_W'(n - 1 - i);
            end
            else if (!found_free)
            begin
                found_free = 1'b1;
                res.first_free = FREE_W'(i);
            end
        end
        res.set_total = CNT_W'(set_bits);
        res.unset_total = CNT_W'(n - set_bits);
        res.no_free = ~found_free;
        return res;
    endfunction

    assign pending_count = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            shadow_map <= '0;
            shadow_count <= CNT_W'(1024);
            expected_words.delete();
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
                shadow_count <= cfg_wdata;
            if (in_valid && !in_stall)
                expected_words.push_back(predict_request(in_data));
            // Compare each taken word against the oldest expectation.
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result word %h", out_data);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want !== out_data)
                    begin
                        if (mismatch_count < 10)
                            $display("result mismatch: expected %p actual %p", want, out_data);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

### dv/bitmap_store_with_find_free_top_test.sv
// Testbench top: clock, reset, stimulus and verdict for the bitmap store.
`timescale 1ns / 100ps
module bitmap_store_with_find_free_top_test;
    import bsff_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_data;
    int          mismatch_count;
    int          pending_count;
    logic        steady_phase = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned cur_count = 1024;

    always #4 clk = ~clk;

    bitmap_store_with_find_free_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    bitmap_store_with_find_free_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .mismatch_count(mismatch_count), .pending_count(pending_count)
    );

    // Receiver stalls at random, except in the steady phase or during a hold-off.
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (steady_phase)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 33);
    end

    // Offers one request word and waits until it is taken; valid stays high afterwards
    // so that a following word can go out back to back.
    task automatic send_word(input op_t op, input int unsigned s, input int unsigned e);
        while (!steady_phase && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{op: op, start_bit: CNT_W'(s), end_bit: CNT_W'(e)};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Waits for the block to drain, then writes the bit count.
    task automatic write_count(input int unsigned value);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_count = value;
    endtask

    // Mostly in-range random request, with some out-of-range noise.
    task automatic send_random;
        int unsigned lim;
        int unsigned s;
        int unsigned e;
        lim = (cur_count > 1024) ? 1024 : cur_count;
        if ($urandom_range(9) == 0)
        begin
            s = $urandom_range(2047);
            e = $urandom_range(2047);
        end
        else
        begin
            e = $urandom_range(lim);
            s = $urandom_range(e);
            if ($urandom_range(3) == 0)
                e = s + $urandom_range(3) < lim ? s + $urandom_range(3) : lim;
        end
        send_word(op_t'($urandom_range(3)), s, e);
    endtask

    initial
    begin
        int unsigned counts[7] = '{1024, 1, 0, 64, 2047, 100, 1024};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: field extremes, every operation and each corner case.
        send_word(OP_QUERY, 0, 0);
        send_word(OP_SET, 0, 1024);
        send_word(OP_QUERY, 1023, 0);
        send_word(OP_TOGGLE, 1023, 0);
        send_word(OP_TOGGLE, 0, 0);
        send_word(OP_CLEAR, 10, 10);
        send_word(OP_CLEAR, 5, 4);
        send_word(OP_SET, 0, 1025);
        send_word(OP_TOGGLE, 1024, 0);
        send_word(OP_QUERY, 2047, 2047);
        send_word(OP_CLEAR, 0, 1024);
        send_word(OP_SET, 2047, 2047);
        send_word(OP_TOGGLE, 63, 0);
        send_word(OP_SET, 60, 130);
        send_word(OP_CLEAR, 64, 65);
        send_word(OP_QUERY, 64, 0);
        // Pressure: receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (4) send_random();
        join
        // Random phases across several bit counts, including the extremes.
        foreach (counts[k])
        begin
            write_count(counts[k]);
            send_word(OP_SET, 0, 0);
            send_word(OP_TOGGLE, 0, 0);
            for (int i = 0; i < 200; i++)
            begin
                steady_phase = (k == 3 && i >= 100 && i < 160);
                send_random();
            end
            steady_phase = 1'b0;
        end
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

### filelist.f
sv/bsff_pkg.sv
sv/bsff_word_unit.sv
sv/bsff_ctrl.sv
sv/bitmap_store_with_find_free_top.sv
dv/bitmap_store_with_find_free_checker.sv
dv/bitmap_store_with_find_free_top_test.sv
